[hw/rtl/sed_pkg.sv]
// shared types, character constants and decode helpers for the string escape decoder
package sed_pkg;

  // escape mode codes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_BSLASH = 3'd1;
  localparam logic [2:0] MODE_OCTAL  = 3'd2;
  localparam logic [2:0] MODE_XSEEN  = 3'd3;
  localparam logic [2:0] MODE_HEX    = 3'd4;

  // characters with a special meaning
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // result queue depth, room for two results per transaction
  localparam int unsigned QUEUE_DEPTH = 4;

  // one decoded result
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       range_warning;
    logic       last;
  } result_t;

  // results of one transaction, compacted to the front
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // data result, not last
  function automatic result_t mk_result(logic [7:0] data, logic warn);
    result_t r;
    r.data_byte     = data;
    r.has_byte      = 1'b1;
    r.range_warning = warn;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  // nibble value of a hex digit character
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  // control code letters, anything else stands for itself
  function automatic logic [7:0] letter_code(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/sed_if.sv]
// valid/ready channel interfaces for the string escape decoder

// raw character channel
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;
  logic       add_terminator;

  modport source (output valid, ch, end_of_string, add_terminator, input ready);
  modport sink (input valid, ch, end_of_string, add_terminator, output ready);
endinterface

// decoded byte channel
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       range_warning;
  logic       last;

  modport source (output valid, data_byte, has_byte, range_warning, last, input ready);
  modport sink (input valid, data_byte, has_byte, range_warning, last, output ready);
endinterface

[hw/rtl/sed_decode.sv]
// escape state registers and combinational decode of one character transaction
module sed_decode #(
  parameter int unsigned HEX_ACCUM_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            ch_i,
  input  logic                  end_of_string_i,
  input  logic                  add_terminator_i,
  output sed_pkg::result_pair_t pair_o
);

  logic [2:0]                mode_q, mode_d;
  logic [8:0]                val_q, val_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [HEX_ACCUM_BITS-1:0] acc_q, acc_d;
  logic                      sat_q, sat_d;

  logic                      a_v, b_v, go_idle, do_plain;
  sed_pkg::result_t          a_res, b_res, oct_res, hex_res, bare_res;
  logic [8:0]                oct_next;
  logic [HEX_ACCUM_BITS-1:0] acc_base;
  logic                      sat_base;
  logic                      hex_ovf;

  // pending escape values as results
  assign oct_res  = sed_pkg::mk_result(val_q[7:0], val_q[8]);
  assign hex_res  = sed_pkg::mk_result(acc_q[7:0], sat_q | (|acc_q[HEX_ACCUM_BITS-1:8]));
  assign oct_next = {val_q[5:0], ch_i[2:0]};

  // hex accumulate starts from zero on the first digit
  assign acc_base = (mode_q == sed_pkg::MODE_XSEEN) ? '0 : acc_q;
  assign sat_base = (mode_q == sed_pkg::MODE_XSEEN) ? 1'b0 : sat_q;
  assign hex_ovf  = |acc_base[HEX_ACCUM_BITS-1:HEX_ACCUM_BITS-4];

  always_comb begin
    bare_res               = sed_pkg::mk_result(sed_pkg::CH_NUL, 1'b0);
    bare_res.has_byte      = 1'b0;
    mode_d   = mode_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    a_v      = 1'b0;
    a_res    = sed_pkg::mk_result(sed_pkg::CH_NUL, 1'b0);
    b_v      = 1'b0;
    b_res    = sed_pkg::mk_result(sed_pkg::CH_NUL, 1'b0);
    go_idle  = 1'b0;
    do_plain = 1'b0;

    if (end_of_string_i) begin
      // flush pending escape, then optional terminator
      case (mode_q)
        sed_pkg::MODE_BSLASH: begin
          a_v = 1'b1;
        end
        sed_pkg::MODE_OCTAL: begin
          a_v   = 1'b1;
          a_res = oct_res;
        end
        sed_pkg::MODE_XSEEN: begin
          a_v   = 1'b1;
          a_res = sed_pkg::mk_result(sed_pkg::CH_X, 1'b0);
        end
        sed_pkg::MODE_HEX: begin
          a_v   = 1'b1;
          a_res = hex_res;
        end
        default: ;
      endcase
      b_v     = add_terminator_i;
      go_idle = 1'b1;
    end else begin
      case (mode_q)
        sed_pkg::MODE_BSLASH: begin
          if (sed_pkg::is_octal(ch_i)) begin
            mode_d = sed_pkg::MODE_OCTAL;
            val_d  = {6'd0, ch_i[2:0]};
            cnt_d  = 2'd1;
          end else if (ch_i == sed_pkg::CH_X) begin
            mode_d = sed_pkg::MODE_XSEEN;
            acc_d  = '0;
            sat_d  = 1'b0;
          end else begin
            go_idle = 1'b1;
            a_v     = 1'b1;
            a_res   = sed_pkg::mk_result(sed_pkg::letter_code(ch_i), 1'b0);
          end
        end
        sed_pkg::MODE_OCTAL: begin
          if (sed_pkg::is_octal(ch_i)) begin
            if (cnt_q >= 2'd2) begin
              // third digit closes the escape
              a_v     = 1'b1;
              a_res   = sed_pkg::mk_result(oct_next[7:0], oct_next[8]);
              go_idle = 1'b1;
            end else begin
              val_d = oct_next;
              cnt_d = cnt_q + 2'd1;
            end
          end else begin
            a_v      = 1'b1;
            a_res    = oct_res;
            go_idle  = 1'b1;
            do_plain = 1'b1;
          end
        end
        sed_pkg::MODE_XSEEN, sed_pkg::MODE_HEX: begin
          if (sed_pkg::is_hex(ch_i)) begin
            mode_d = sed_pkg::MODE_HEX;
            if (sat_base || hex_ovf) begin
              acc_d = '1;
              sat_d = 1'b1;
            end else begin
              acc_d = {acc_base[HEX_ACCUM_BITS-5:0], sed_pkg::hex_val(ch_i)};
              sat_d = 1'b0;
            end
          end else begin
            a_v      = 1'b1;
            a_res    = (mode_q == sed_pkg::MODE_XSEEN) ?
                       sed_pkg::mk_result(sed_pkg::CH_X, 1'b0) : hex_res;
            go_idle  = 1'b1;
            do_plain = 1'b1;
          end
        end
        default: begin
          go_idle  = 1'b1;
          do_plain = 1'b1;
        end
      endcase
    end

    if (go_idle) begin
      mode_d = sed_pkg::MODE_IDLE;
      val_d  = '0;
      cnt_d  = '0;
      acc_d  = '0;
      sat_d  = 1'b0;
    end

    // ordinary character handling in idle mode or after a closed escape
    if (do_plain) begin
      if (ch_i == sed_pkg::CH_BSLASH) begin
        mode_d = sed_pkg::MODE_BSLASH;
      end else begin
        b_v   = 1'b1;
        b_res = sed_pkg::mk_result(ch_i, 1'b0);
      end
    end
  end

  // compact results and mark the end of a string
  always_comb begin
    pair_o.cnt    = {1'b0, a_v} + {1'b0, b_v};
    pair_o.first  = a_v ? a_res : b_res;
    pair_o.second = b_res;
    if (end_of_string_i) begin
      if (!a_v && !b_v) begin
        pair_o.cnt   = 2'd1;
        pair_o.first = bare_res;
      end
      if (a_v && b_v) begin
        pair_o.second.last = 1'b1;
      end else begin
        pair_o.first.last = 1'b1;
      end
    end
  end

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sed_pkg::MODE_IDLE;
      val_q  <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      sat_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      sat_q  <= sat_d;
    end
  end

endmodule

[hw/rtl/sed_out_queue.sv]
// small result queue that takes up to two results per cycle and hands out one
module sed_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sed_pkg::result_pair_t pair_i,
  input  logic                  pop_i,
  output logic                  room_o,
  output logic                  valid_o,
  output sed_pkg::result_t      head_o,
  output logic [$clog2(sed_pkg::QUEUE_DEPTH):0] count_o
);

  localparam int unsigned PW = $clog2(sed_pkg::QUEUE_DEPTH);
  localparam logic [PW:0] ROOM_LIMIT = (PW + 1)'(sed_pkg::QUEUE_DEPTH - 2);

  sed_pkg::result_t mem_q [sed_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      count_q;
  logic [1:0]       push_n;
  logic             pop;

  assign push_n  = push_i ? pair_i.cnt : 2'd0;
  assign pop     = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room_o  = (count_q <= ROOM_LIMIT);
  assign count_o = count_q;

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= pair_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= pair_i.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PW'(push_n);
      rd_q    <= rd_q + PW'(pop);
      count_q <= count_q + (PW + 1)'(push_n) - (PW + 1)'(pop);
    end
  end

endmodule

[hw/rtl/string_escape_decoder.sv]
// top level of the string escape decoder
// Takes one raw string character per transaction on in_if and returns decoded bytes on
// out_if. Backslash escapes (octal, hex, control letters) are resolved combinationally against
// the escape state registers; each transaction yields zero, one or two results,
// which go into a four-entry result queue. A new character is accepted every cycle while the
// queue holds at most two results, so the input runs at one transaction per cycle as long as
// the consumer keeps up; the single output port drains one result per cycle, which bounds the
// rate when escapes closed by another character produce two results. An end transaction
// always produces at least one result, the final one flagged by last. HEX_ACCUM_BITS sets
// the width of the saturating hex accumulator.
module string_escape_decoder #(
  parameter int unsigned HEX_ACCUM_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sed_in_if.sink     in_if,
  sed_out_if.source  out_if
);

  logic                  take;
  logic                  room;
  sed_pkg::result_pair_t pair;
  sed_pkg::result_t      head;
  logic [$clog2(sed_pkg::QUEUE_DEPTH):0] q_count;

  assign in_if.ready = room;
  assign take        = in_if.valid && room;

  // escape decode
  sed_decode #(
    .HEX_ACCUM_BITS (HEX_ACCUM_BITS)
  ) u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .ch_i             (in_if.ch),
    .end_of_string_i  (in_if.end_of_string),
    .add_terminator_i (in_if.add_terminator),
    .pair_o           (pair)
  );

  // result queue
  sed_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .pair_i  (pair),
    .pop_i   (out_if.ready),
    .room_o  (room),
    .valid_o (out_if.valid),
    .head_o  (head),
    .count_o (q_count)
  );

  assign out_if.data_byte     = head.data_byte;
  assign out_if.has_byte      = head.has_byte;
  assign out_if.range_warning = head.range_warning;
  assign out_if.last          = head.last;

  // an end transaction always yields a result
  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_if.end_of_string) |-> (pair.cnt != 2'd0))
    else $error("end transaction produced no result");

  // never more than two results per transaction
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair.cnt != 2'd3)
    else $error("decode produced more than two results");

  // queue fill stays within its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(sed_pkg::QUEUE_DEPTH) + 1)'(sed_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // backpressure only while results are waiting
  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with an empty result queue");

endmodule
